>>> rtl/dcm_pkg.sv
// Shared types and constants for the disparity color map block.
package dcm_pkg;

  localparam int ROWS_MAX       = 8;
  localparam int TABLE_ROWS_DEF = 8;
  localparam int ROW_IDX_W      = 3;
  localparam int Q_W            = 17;
  localparam int FRAC_W         = 16;
  localparam int SUM_W          = 11;
  localparam int DISP_W         = 15;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;

  localparam logic [Q_W-1:0]    ONE_Q16      = 17'h10000;
  localparam logic [DISP_W-1:0] MAX_DISP_RST = 15'd3072;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_01  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_23  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_45  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_67  = 3'd4;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_ONE,
    MODE_DIV
  } mode_t;

  typedef enum logic {
    CS_IDLE,
    CS_CALC
  } cum_state_t;

  typedef logic [ROWS_MAX-1:0][7:0]     wt_arr_t;
  typedef logic [ROWS_MAX-1:0][Q_W-1:0] cum_arr_t;

endpackage

>>> rtl/dcm_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module dcm_div_pipe #(
  parameter int DEN_W  = 15,
  parameter int QB_W   = 16,
  parameter int SIDE_W = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [DEN_W+QB_W-1:0] in_num,
  input  logic [DEN_W-1:0]      in_den,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [QB_W-1:0]       out_q,
  output logic [SIDE_W-1:0]     out_side
);

  logic              vld_r  [QB_W];
  logic [DEN_W-1:0]  rem_r  [QB_W];
  logic [QB_W-1:0]   lo_r   [QB_W];
  logic [QB_W-1:0]   q_r    [QB_W];
  logic [DEN_W-1:0]  den_r  [QB_W];
  logic [SIDE_W-1:0] side_r [QB_W];

  for (genvar s = 0; s < QB_W; s++) begin : g_stage
    logic              pv;
    logic [DEN_W-1:0]  prem;
    logic [QB_W-1:0]   plo;
    logic [QB_W-1:0]   pq;
    logic [DEN_W-1:0]  pden;
    logic [SIDE_W-1:0] pside;
    logic [DEN_W:0]    rem2;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = in_num[DEN_W+QB_W-1:QB_W];
      assign plo   = in_num[QB_W-1:0];
      assign pq    = '0;
      assign pden  = in_den;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld_r[s-1];
      assign prem  = rem_r[s-1];
      assign plo   = lo_r[s-1];
      assign pq    = q_r[s-1];
      assign pden  = den_r[s-1];
      assign pside = side_r[s-1];
    end

    always_comb begin
      rem2 = {prem, plo[QB_W-1]};
      ge   = (rem2 >= {1'b0, pden});
      diff = rem2 - {1'b0, pden};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
        lo_r[s]   <= {plo[QB_W-2:0], 1'b0};
        q_r[s]    <= {pq[QB_W-2:0], ge};
        den_r[s]  <= pden;
        side_r[s] <= pside;
      end
    end
  end

  assign out_valid = vld_r[QB_W-1];
  assign out_q     = q_r[QB_W-1];
  assign out_side  = side_r[QB_W-1];

endmodule

>>> rtl/dcm_cum_calc.sv
// Sequencer that derives the normalized cumulative weight boundaries.
module dcm_cum_calc #(
  parameter int TABLE_ROWS = dcm_pkg::TABLE_ROWS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  dcm_pkg::wt_arr_t             weights,
  input  logic [dcm_pkg::SUM_W-1:0]    sum,
  output logic                         busy,
  output dcm_pkg::cum_arr_t            cum
);
  import dcm_pkg::*;

  localparam int NUM_W = SUM_W + FRAC_W;

  cum_state_t             state_r, state_nxt;
  logic [ROW_IDX_W-1:0]   k_r;
  logic [4:0]             bit_r;
  logic [SUM_W-1:0]       rem_r;
  logic [Q_W-1:0]         q_r;
  cum_arr_t               cum_r;

  logic [SUM_W-1:0]       pre;
  logic [NUM_W-1:0]       numer;
  logic [SUM_W:0]         rem2;
  logic [SUM_W:0]         diff;
  logic                   ge;
  logic                   last_bit;

  always_comb begin
    pre = '0;
    for (int j = 0; j < ROWS_MAX; j++) begin
      if (j < TABLE_ROWS && ROW_IDX_W'(j) < k_r) begin
        pre = pre + SUM_W'(weights[j]);
      end
    end
    numer    = {pre, {FRAC_W{1'b0}}};
    rem2     = {rem_r, numer[bit_r]};
    ge       = (rem2 >= {1'b0, sum});
    diff     = rem2 - {1'b0, sum};
    last_bit = (bit_r == 5'd0);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: if (start) state_nxt = CS_CALC;
      CS_CALC: begin
        if (start) begin
          state_nxt = CS_CALC;
        end else if (last_bit && k_r == ROW_IDX_W'(TABLE_ROWS - 1)) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r == CS_CALC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r   <= '0;
      bit_r <= 5'(NUM_W - 1);
      rem_r <= '0;
      q_r   <= '0;
    end else if (state_r == CS_CALC) begin
      if (last_bit) begin
        cum_r[k_r] <= {q_r[Q_W-2:0], ge};
        k_r   <= k_r + 1'b1;
        bit_r <= 5'(NUM_W - 1);
        rem_r <= '0;
        q_r   <= '0;
      end else begin
        rem_r <= ge ? diff[SUM_W-1:0] : rem2[SUM_W-1:0];
        q_r   <= {q_r[Q_W-2:0], ge};
        bit_r <= bit_r - 1'b1;
      end
    end
  end

  assign cum = cum_r;

endmodule

>>> rtl/disparity_to_color_map.sv
// Top level: disparity pixel stream mapped to RGB through a weighted color table.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | in_disparity, in_frame_end_in
//   out     | output    | out_valid / out_ready | out_red, out_green, out_blue,
//           |           |                       | out_frame_end_out
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// One word per clock unless the output is held or a rebuild runs. Stages:
// input register, 16 stages of the normalizing divider, segment pick, weight
// multiply, 17 stages of the blend divider, blend select and the output register.
// After a write to a table register the boundaries are rebuilt serially;
// in_ready stays low meanwhile. Reset needs no rebuild.
// A stalled output freezes every stage; nothing is dropped or repeated.
module disparity_to_color_map #(
  parameter int TABLE_ROWS = dcm_pkg::TABLE_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                in_disparity,
  input  logic                              in_frame_end_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic                              out_frame_end_out,
  input  logic                              cfg_we,
  input  logic [dcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dcm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dcm_pkg::*;

  // configuration
  logic [DISP_W-1:0]      max_disp_r;
  logic [63:0]            rows_r [4];
  logic                   start;
  logic                   busy;
  wt_arr_t                weights;
  logic [31:0]            row_word [ROWS_MAX];
  logic [SUM_W-1:0]       sum;
  logic                   sum_zero;
  cum_arr_t               cum;

  // pipeline
  logic                   en;
  logic                   a_v_r;
  logic signed [15:0]     a_disp_r;
  logic                   a_fe_r;
  logic [DISP_W-1:0]      m_eff;
  mode_t                  a_mode;
  logic [DISP_W+FRAC_W-1:0] a_num;

  logic                   b_v;
  logic [FRAC_W-1:0]      b_q;
  logic [2:0]             b_side;
  mode_t                  b_mode;
  logic [Q_W-1:0]         b_val;
  logic                   b_found;
  logic [ROW_IDX_W-1:0]   b_sel;

  logic                   c_v_r;
  logic [ROW_IDX_W-1:0]   c_i_r;
  logic [Q_W-1:0]         c_diff_r;
  logic                   c_past_r;
  logic                   c_fe_r;

  logic                   d_v_r;
  logic [ROW_IDX_W-1:0]   d_i_r;
  logic [27:0]            d_prod_r;
  logic [7:0]             d_wi_r;
  logic                   d_past_r;
  logic                   d_fe_r;
  logic [23:0]            d_thr;
  logic                   d_sat;

  logic                   t_v;
  logic [Q_W-1:0]         t_q;
  logic [6:0]             t_side;
  logic [Q_W-1:0]         t_val;
  logic [ROW_IDX_W-1:0]   t_lo;

  logic                   e_v_r;
  logic [Q_W-1:0]         e_t_r;
  logic [ROW_IDX_W-1:0]   e_lo_r;
  logic [ROW_IDX_W-1:0]   e_hi_r;
  logic                   e_fe_r;
  logic [24:0]            mix [3];

  logic                   out_valid_r;
  logic [7:0]             out_red_r;
  logic [7:0]             out_green_r;
  logic [7:0]             out_blue_r;
  logic                   out_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_disp_r <= MAX_DISP_RST;
      for (int r = 0; r < 4; r++) rows_r[r] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_DISP: max_disp_r <= cfg_data[DISP_W-1:0];
        CFG_ROWS_01:  rows_r[0]  <= cfg_data;
        CFG_ROWS_23:  rows_r[1]  <= cfg_data;
        CFG_ROWS_45:  rows_r[2]  <= cfg_data;
        CFG_ROWS_67:  rows_r[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    start = cfg_we && (cfg_index == CFG_ROWS_01 || cfg_index == CFG_ROWS_23 ||
                       cfg_index == CFG_ROWS_45 || cfg_index == CFG_ROWS_67);
    sum = '0;
    for (int r = 0; r < ROWS_MAX; r++) begin
      row_word[r] = rows_r[r/2][(r%2)*32 +: 32];
      weights[r]  = row_word[r][31:24];
      if (r < TABLE_ROWS) sum = sum + SUM_W'(weights[r]);
    end
    sum_zero = (sum == '0);
  end

  dcm_cum_calc #(.TABLE_ROWS(TABLE_ROWS)) u_cum (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .weights (weights),
    .sum     (sum),
    .busy    (busy),
    .cum     (cum)
  );

  // advance the whole pipe unless the output word is held
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en && !busy;

  // stage A: capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_disp_r <= in_disparity;
      a_fe_r   <= in_frame_end_in;
    end
  end

  always_comb begin
    m_eff = (max_disp_r == '0) ? DISP_W'(1) : max_disp_r;
    if (a_disp_r <= 16'sd0) begin
      a_mode = MODE_ZERO;
    end else if (a_disp_r[DISP_W-1:0] >= m_eff) begin
      a_mode = MODE_ONE;
    end else begin
      a_mode = MODE_DIV;
    end
    a_num = {a_disp_r[DISP_W-1:0], {FRAC_W{1'b0}}};
  end

  dcm_div_pipe #(.DEN_W(DISP_W), .QB_W(FRAC_W), .SIDE_W(3)) u_div_v (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_v_r),
    .in_num    (a_num),
    .in_den    (m_eff),
    .in_side   ({a_mode, a_fe_r}),
    .out_valid (b_v),
    .out_q     (b_q),
    .out_side  (b_side)
  );

  // stage C: segment pick
  always_comb begin
    b_mode = mode_t'(b_side[2:1]);
    case (b_mode)
      MODE_ZERO: b_val = '0;
      MODE_ONE:  b_val = ONE_Q16;
      default:   b_val = {1'b0, b_q};
    endcase
    b_found = 1'b0;
    b_sel   = '0;
    for (int i = 0; i < ROWS_MAX - 1; i++) begin
      if (i + 1 < TABLE_ROWS && !b_found && b_val < cum[i+1]) begin
        b_found = 1'b1;
        b_sel   = ROW_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v;
      d_v_r <= c_v_r;
      e_v_r <= t_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_i_r    <= b_sel;
      c_diff_r <= b_val - cum[b_sel];
      c_past_r <= !b_found;
      c_fe_r   <= b_side[0];
    end
  end

  // stage D: scale the offset by the weight sum
  always_ff @(posedge clk) begin
    if (en) begin
      d_i_r    <= c_i_r;
      d_prod_r <= 28'(c_diff_r) * 28'(sum);
      d_wi_r   <= weights[c_i_r];
      d_past_r <= c_past_r;
      d_fe_r   <= c_fe_r;
    end
  end

  // quotient above one saturates; saturated words still pass the divider, flagged in its side payload
  always_comb begin
    d_thr = {d_wi_r, 16'h0000} + 24'(d_wi_r);
    d_sat = (d_prod_r >= 28'(d_thr));
  end

  dcm_div_pipe #(.DEN_W(8), .QB_W(Q_W), .SIDE_W(7)) u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_v_r),
    .in_num    (d_prod_r[24:0]),
    .in_den    (d_wi_r),
    .in_side   ({d_i_r, d_past_r, d_sat, (d_wi_r == 8'd0), d_fe_r}),
    .out_valid (t_v),
    .out_q     (t_q),
    .out_side  (t_side)
  );

  // stage E: blend weight and row pair
  always_comb begin
    if (t_side[3]) begin
      t_val = ONE_Q16;
      t_lo  = ROW_IDX_W'(TABLE_ROWS - 2);
    end else begin
      t_lo = t_side[6:4];
      if (t_side[1])      t_val = '0;
      else if (t_side[2]) t_val = ONE_Q16;
      else                t_val = t_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_fe_r <= t_side[0];
      if (sum_zero) begin
        e_t_r  <= '0;
        e_lo_r <= '0;
        e_hi_r <= '0;
      end else begin
        e_t_r  <= t_val;
        e_lo_r <= t_lo;
        e_hi_r <= t_lo + 1'b1;
      end
    end
  end

  // stage F: linear blend of the two colors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mix[k] = 25'(ONE_Q16 - e_t_r) * 25'(row_word[e_lo_r][k*8 +: 8])
             + 25'(e_t_r) * 25'(row_word[e_hi_r][k*8 +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_red_r   <= mix[0][23:16];
      out_green_r <= mix[1][23:16];
      out_blue_r  <= mix[2][23:16];
      out_fe_r    <= e_fe_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = out_red_r;
  assign out_green         = out_green_r;
  assign out_blue          = out_blue_r;
  assign out_frame_end_out = out_fe_r;

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready) else $error("word accepted during boundary rebuild");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> a_v_r) else $error("accepted word lost at entry");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_red) && $stable(out_fe_r)))
    else $error("held output word changed");

  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    e_v_r |-> (e_t_r <= ONE_Q16)) else $error("blend weight above one");

endmodule

>>> sim/disparity_to_color_map_test.sv
// Testbench for disparity_to_color_map: directed, random and backpressure tests.
module disparity_to_color_map_test;
  import dcm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PIPE_DEPTH   = 40;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [15:0]      in_disparity = '0;
  logic                    in_frame_end_in = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [7:0]              out_red, out_green, out_blue;
  logic                    out_frame_end_out;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // shadow copy of the configuration
  logic [DISP_W-1:0]       max_disp_shadow = MAX_DISP_RST;
  logic [63:0]             table_shadow [4] = '{default: '0};

  pixel_t expected_pixels [$];
  int     mismatches = 0;
  int     cycles = 0;
  int     sender_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_off = 0;

  disparity_to_color_map u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_disparity, .in_frame_end_in,
    .out_valid, .out_ready, .out_red, .out_green, .out_blue, .out_frame_end_out,
    .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int row_byte(int r, int b);
    logic [31:0] w;
    w = table_shadow[r >> 1][(r & 1) * 32 +: 32];
    return (w >> (b * 8)) & 8'hFF;
  endfunction

  function automatic pixel_t map_pixel(logic signed [15:0] d, logic fe);
    longint unsigned m, v, sum, pre, t, mix;
    longint unsigned cum [8];
    int lo, hi, i, k, wi;
    pixel_t p;
    m = (max_disp_shadow == 0) ? 1 : max_disp_shadow;
    if (d <= 0) v = 0;
    else if (longint'(d) >= m) v = 65536;
    else v = (longint'(d) << 16) / m;
    sum = 0;
    for (k = 0; k < 8; k++) sum += row_byte(k, 3);
    lo = 0; hi = 0; t = 0;
    if (sum != 0) begin
      pre = 0;
      for (k = 0; k < 8; k++) begin
        cum[k] = (pre << 16) / sum;
        pre += row_byte(k, 3);
      end
      for (i = 0; i < 7; i++)
        if (v < cum[i + 1]) break;
      if (i >= 7) begin
        // past the last boundary: end of the last segment
        lo = 6; hi = 7; t = 65536;
      end else begin
        wi = row_byte(i, 3);
        lo = i; hi = i + 1;
        if (wi == 0 || v < cum[i]) t = 0;
        else begin
          t = ((v - cum[i]) * sum) / wi;
          if (t > 65536) t = 65536;
        end
      end
    end
    mix = (65536 - t) * row_byte(lo, 0) + t * row_byte(hi, 0);
    p.red = 8'(mix >> 16);
    mix = (65536 - t) * row_byte(lo, 1) + t * row_byte(hi, 1);
    p.green = 8'(mix >> 16);
    mix = (65536 - t) * row_byte(lo, 2) + t * row_byte(hi, 2);
    p.blue = 8'(mix >> 16);
    p.frame_end = fe;
    return p;
  endfunction

  // drive one pixel word and record its color once accepted
  task automatic send_pixel(logic signed [15:0] d, logic fe);
    if ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_disparity    <= d;
    in_frame_end_in <= fe;
    do @(posedge clk); while (!in_ready);
    expected_pixels.push_back(map_pixel(d, fe));
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_DISP) max_disp_shadow = data[DISP_W-1:0];
    else if (idx <= CFG_ROWS_67) table_shadow[idx - 1] = data;
  endtask

  task automatic load_table(logic [63:0] r01, logic [63:0] r23, logic [63:0] r45,
                            logic [63:0] r67);
    write_reg(CFG_ROWS_01, r01);
    write_reg(CFG_ROWS_23, r23);
    write_reg(CFG_ROWS_45, r45);
    write_reg(CFG_ROWS_67, r67);
  endtask

  function automatic logic [63:0] random_rows();
    logic [63:0] r;
    r = {$urandom, $urandom};
    // zero some weights so empty segments occur
    if ($urandom_range(3) == 0) r[31:24] = 8'h00;
    if ($urandom_range(3) == 0) r[63:56] = 8'h00;
    return r;
  endfunction

  function automatic logic signed [15:0] random_disparity();
    int m;
    m = (max_disp_shadow == 0) ? 1 : max_disp_shadow;
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, (m + m / 8 > 32767) ? 32767 : m + m / 8));
  endfunction

  task automatic test_reset_state;
    // zero weight sum after reset: row 0 color, all zero
    send_pixel(16'sd0, 1'b0);
    send_pixel(16'sd1536, 1'b1);
    send_pixel(16'sd32767, 1'b0);
    drain();
  endtask

  task automatic test_directed;
    load_table(64'h40_2010F0_20_F01020, 64'h10_808080_30_00FF00,
               64'h00_123456_08_0000FF, 64'h01_FFFFFF_18_FF00FF);
    write_reg(CFG_MAX_DISP, 15'd3072);
    send_pixel(-16'sd32768, 1'b0);
    send_pixel(-16'sd1, 1'b1);
    send_pixel(16'sd0, 1'b0);
    send_pixel(16'sd1, 1'b0);
    send_pixel(16'sd1000, 1'b1);
    send_pixel(16'sd2000, 1'b0);
    send_pixel(16'sd3071, 1'b0);
    send_pixel(16'sd3072, 1'b1);
    send_pixel(16'sd32767, 1'b0);
    drain();
    // extremes of full scale, including a zero write
    write_reg(CFG_MAX_DISP, 15'd1);
    send_pixel(16'sd1, 1'b0);
    send_pixel(16'sd0, 1'b1);
    drain();
    write_reg(CFG_MAX_DISP, 15'd0);
    send_pixel(16'sd1, 1'b0);
    send_pixel(-16'sd5, 1'b0);
    drain();
    write_reg(CFG_MAX_DISP, 15'd32767);
    send_pixel(16'sd16384, 1'b1);
    send_pixel(16'sd32766, 1'b0);
    send_pixel(16'sd32767, 1'b0);
    drain();
    // weight only in rows 1 and 7: full scale lands past the last boundary
    load_table(64'hFF_FFFFFF_00_FFFFFF, 64'h00_AAAAAA_00_555555, 64'h0,
               64'hFF_0F1E2D_00_C0B0A0);
    // index beyond the register list changes nothing
    write_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pixel(16'sd100, 1'b0);
    send_pixel(16'sd32767, 1'b1);
    drain();
    // weights only in row 0
    load_table(64'h00_FFFFFF_FF_000000, 64'h0, 64'h0, 64'h0);
    send_pixel(16'sd8000, 1'b0);
    send_pixel(16'sd32000, 1'b1);
    drain();
  endtask

  task automatic test_random(int idle, int stall, int n);
    sender_idle_pct = idle;
    recv_stall_pct  = stall;
    load_table(random_rows(), random_rows(), random_rows(), random_rows());
    case ($urandom_range(2))
      0: write_reg(CFG_MAX_DISP, 15'd1 + $urandom_range(0, 63));
      1: write_reg(CFG_MAX_DISP, 15'd32767 - $urandom_range(0, 63));
      default: write_reg(CFG_MAX_DISP, $urandom_range(1, 32767));
    endcase
    repeat (n) send_pixel(random_disparity(), $urandom_range(1));
    drain();
  endtask

  task automatic test_backpressure;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_off = 300;
    repeat (120) send_pixel(random_disparity(), $urandom_range(1));
    // pause until everything has come back
    drain();
    repeat (20) send_pixel(random_disparity(), $urandom_range(1));
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected word: red %0d green %0d blue %0d", out_red, out_green,
               out_blue);
        mismatches++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_red !== exp_px.red) begin
          $error("red: expected %0d, got %0d", exp_px.red, out_red);
          mismatches++;
        end
        if (out_green !== exp_px.green) begin
          $error("green: expected %0d, got %0d", exp_px.green, out_green);
          mismatches++;
        end
        if (out_blue !== exp_px.blue) begin
          $error("blue: expected %0d, got %0d", exp_px.blue, out_blue);
          mismatches++;
        end
        if (out_frame_end_out !== exp_px.frame_end) begin
          $error("frame_end_out: expected %0d, got %0d", exp_px.frame_end,
                 out_frame_end_out);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed();
    repeat (3) test_random(7, 80, 60);
    repeat (3) test_random(80, 7, 60);
    repeat (3) test_random(0, 0, 60);
    test_backpressure();
    repeat (PIPE_DEPTH) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
rtl/dcm_pkg.sv
rtl/dcm_div_pipe.sv
rtl/dcm_cum_calc.sv
rtl/disparity_to_color_map.sv
sim/disparity_to_color_map_test.sv
